>>> rtl/core/edit_distance_engine_core_assert.svh
// Assertion macros shared by the edit distance core.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef EDIT_DISTANCE_ENGINE_CORE_ASSERT_SVH
`define EDIT_DISTANCE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EDE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define EDE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/ede_pkg.sv
// Shared types and constants for the edit distance core.
// No dependencies; used by ede_head, ede_cell and edit_distance_engine_core.
`timescale 1ns / 1ps

package ede_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int FUNC_W      = 2;
	localparam int SYM_W       = 8;
	localparam int COST_W      = 16;
	localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

	// Request function codes, also used as token opcodes in the chain
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

	// Token handed from cell to cell.
	// left: new cost of the previous column (query), or running distance (finish)
	// diag: old cost of the previous column (query)
	// mark: byte already placed (append), overflow flag (finish)
	typedef struct packed {
		logic              valid;
		logic [FUNC_W-1:0] op;
		logic [SYM_W-1:0]  sym;
		logic [COST_W-1:0] left;
		logic [COST_W-1:0] diag;
		logic              mark;
	} tok_t;

endpackage

>>> rtl/core/ede_head.sv
// Head of the cell chain: reference length, query count and overflow flag.
// Turns each request into a token for the first cell. Depends on ede_pkg.
`timescale 1ns / 1ps

module ede_head #(
	parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         req_valid,
	input  logic [ede_pkg::FUNC_W-1:0]   func,
	input  logic [ede_pkg::SYM_W-1:0]    symbol,
	output ede_pkg::tok_t                tok_o
);
	import ede_pkg::*;

	localparam int LEN_W = $clog2(MAX_LEN + 1);

	logic [LEN_W-1:0]  len_q, len_d;
	logic [COST_W-1:0] qcount_q, qcount_d, qcount_inc;
	logic              ovf_q, ovf_d;
	tok_t              tok_q, tok_d;

	// Saturating query byte count (also column zero of the row)
	assign qcount_inc = (qcount_q == COST_SAT) ? qcount_q : qcount_q + 1'b1;

	// Decode the request into head state updates and a token
	always_comb begin
		len_d      = len_q;
		qcount_d   = qcount_q;
		ovf_d      = ovf_q;
		tok_d      = '0;
		tok_d.op   = func;
		tok_d.sym  = symbol;
		tok_d.valid = req_valid;
		if (req_valid) begin
			case (func)
				FUNC_APPEND: begin
					if (len_q < LEN_W'(MAX_LEN)) begin
						len_d    = len_q + 1'b1;
						qcount_d = '0;
					end else begin
						// drop the byte and flag it
						ovf_d       = 1'b1;
						tok_d.valid = 1'b0;
					end
				end
				FUNC_QUERY: begin
					qcount_d   = qcount_inc;
					tok_d.left = qcount_inc;
					tok_d.diag = qcount_q;
				end
				FUNC_FINISH: begin
					tok_d.left = qcount_q;
					tok_d.mark = ovf_q;
					qcount_d   = '0;
				end
				FUNC_CLEAR: begin
					len_d    = '0;
					ovf_d    = 1'b0;
					qcount_d = '0;
				end
				default: begin
					tok_d.valid = 1'b0;
				end
			endcase
		end
	end

	// Advance head state and the token with the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			qcount_q <= '0;
			ovf_q    <= 1'b0;
			tok_q    <= '0;
		end else if (advance) begin
			len_q    <= len_d;
			qcount_q <= qcount_d;
			ovf_q    <= ovf_d;
			tok_q    <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

>>> rtl/core/ede_cell.sv
// One reference position of the edit distance chain: byte, active bit, cost.
// Updates its column from the passing token and hands it on. Depends on ede_pkg.
`timescale 1ns / 1ps

module ede_cell #(
	parameter int IDX = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  ede_pkg::tok_t  tok_i,
	output ede_pkg::tok_t  tok_o
);
	import ede_pkg::*;

	localparam logic [COST_W-1:0] COST_INIT = COST_W'(IDX);

	logic [SYM_W-1:0]  ref_q, ref_d;
	logic              active_q, active_d;
	logic [COST_W-1:0] cost_q, cost_d;
	logic [COST_W:0]   left_p1, up_p1, sub_c, min_lu, min_all;
	logic [COST_W-1:0] cost_new;
	tok_t              tok_q, tok_d;

	// Edit step: min of insertion, deletion, substitution, saturated
	assign left_p1  = {1'b0, tok_i.left} + 1'b1;
	assign up_p1    = {1'b0, cost_q} + 1'b1;
	assign sub_c    = {1'b0, tok_i.diag} + {{COST_W{1'b0}}, (ref_q != tok_i.sym)};
	assign min_lu   = (left_p1 < up_p1) ? left_p1 : up_p1;
	assign min_all  = (min_lu < sub_c) ? min_lu : sub_c;
	assign cost_new = min_all[COST_W] ? COST_SAT : min_all[COST_W-1:0];

	// Apply the token to this column
	always_comb begin
		ref_d    = ref_q;
		active_d = active_q;
		cost_d   = cost_q;
		tok_d    = tok_i;
		if (tok_i.valid) begin
			case (tok_i.op)
				FUNC_APPEND: begin
					cost_d = COST_INIT;
					// first empty cell takes the byte
					if (!active_q && !tok_i.mark) begin
						ref_d      = tok_i.sym;
						active_d   = 1'b1;
						tok_d.mark = 1'b1;
					end
				end
				FUNC_QUERY: begin
					if (active_q) begin
						cost_d     = cost_new;
						tok_d.left = cost_new;
						tok_d.diag = cost_q;
					end
				end
				FUNC_FINISH: begin
					// last active cell leaves its cost as the distance
					if (active_q) begin
						tok_d.left = cost_q;
					end
					cost_d = COST_INIT;
				end
				FUNC_CLEAR: begin
					active_d = 1'b0;
					cost_d   = COST_INIT;
				end
				default: begin
					cost_d = cost_q;
				end
			endcase
		end
	end

	// Column state and the token handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cost_q   <= COST_INIT;
			tok_q    <= '0;
		end else if (advance) begin
			active_q <= active_d;
			cost_q   <= cost_d;
			tok_q    <= tok_d;
		end
	end

	// Reference byte, no reset
	always_ff @(posedge clk) begin
		if (advance) begin
			ref_q <= ref_d;
		end
	end

	assign tok_o = tok_q;

endmodule

>>> rtl/core/edit_distance_engine_core.sv
// Channel  | Handshake             | Payload
// request  | req_valid, req_ready  | func, symbol
// response | rsp_valid, rsp_ready  | distance, overflow
//
// One request is taken every cycle while no response stalls; the chain of
// MAX_LEN cells is a systolic wavefront, so a query byte goes through the
// head register, then each cell register; a finish response is registered.
// A stalled response freezes the whole chain; req_ready is low only then.
// Reset empties the reference and re-arms the row; no clearing pass.
// Top level of the edit distance core. Depends on ede_pkg, ede_head, ede_cell
// and edit_distance_engine_core_assert.svh.
`timescale 1ns / 1ps
`include "edit_distance_engine_core_assert.svh"

module edit_distance_engine_core #(
	parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [ede_pkg::FUNC_W-1:0]   func,
	input  logic [ede_pkg::SYM_W-1:0]    symbol,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [ede_pkg::COST_W-1:0]   distance,
	output logic                         overflow
);
	import ede_pkg::*;

	logic              advance;
	tok_t              chain [0:MAX_LEN];
	tok_t              tail;
	logic              rsp_valid_q;
	logic [COST_W-1:0] distance_q;
	logic              overflow_q;

	// Move the chain unless a response is held up
	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = advance;

	ede_head #(
		.MAX_LEN (MAX_LEN)
	) u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.req_valid (req_valid),
		.func      (func),
		.symbol    (symbol),
		.tok_o     (chain[0])
	);

	// One cell per reference position
	for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
		ede_cell #(
			.IDX (j + 1)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_i   (chain[j]),
			.tok_o   (chain[j+1])
		);
	end

	assign tail = chain[MAX_LEN];

	// Capture finish tokens leaving the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= tail.valid && (tail.op == FUNC_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			distance_q <= tail.left;
			overflow_q <= tail.mark;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign distance  = distance_q;
	assign overflow  = overflow_q;

	// A held response freezes the token leaving the chain
	`EDE_ASSERT_NEXT(a_stall_holds_tail, !advance, $stable(tail))
	// A response only comes from a finish token
	`EDE_ASSERT_NEXT(a_rsp_from_finish, advance && !(tail.valid && tail.op == FUNC_FINISH),
		!rsp_valid)
	// Stall only when a response waits
	`EDE_ASSERT_NOW(a_stall_cause, !req_ready, rsp_valid && !rsp_ready)

endmodule
